>>> rtl/itc_pkg.sv
package itc_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMask = 17'h1ffff;
  localparam logic [16:0] FullCountZero = 17'h10000;

  // input action codes
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_GATE  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  localparam logic [1:0] AddrControl = 2'd3;

  // per-counter state
  typedef struct packed {
    logic [15:0] reload_value;
    logic [16:0] current_count;
    logic [2:0]  counter_mode;
    logic [1:0]  read_access_state;
    logic [1:0]  write_access_state;
    logic [16:0] output_latch;
    logic        latch_held;
    logic        reread_pending;
    logic [7:0]  status_byte;
    logic        status_pending;
    logic [7:0]  control_copy;
    logic        out_level;
    logic        gate_store;
    logic        terminal_hit;
    logic        count_enabled;
    logic        reload_pending;
    logic        first_load;
    logic        awaiting_count;
  } cnt_state_t;

  // decoded request for one counter
  typedef struct packed {
    logic       wr_data;
    logic       rd_data;
    logic       gate_chg;
    logic       tick;
    logic       ctl_write;
    logic       rb_count;
    logic       rb_status;
    logic [7:0] data;
    logic       gate_level;
  } cnt_req_t;

endpackage

>>> rtl/itc_counter.sv
module itc_counter
  import itc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       gate_init,
  input  logic       term_init,
  input  cnt_req_t   req,
  output logic [7:0] rd_byte,
  output logic       out_level
);

  cnt_state_t st, st_next;

  function automatic logic [16:0] full_cnt(input logic [15:0] r);
    full_cnt = (r == 16'd0) ? FullCountZero : {1'b0, r};
  endfunction

  function automatic logic [16:0] live_cnt(input cnt_state_t s);
    live_cnt = (s.counter_mode == 3'd2) ? s.current_count + 17'd1 : s.current_count;
  endfunction

  // load behavior after a count write
  function automatic cnt_state_t do_load(input cnt_state_t si);
    cnt_state_t s;
    logic [16:0] n;
    s = si;
    n = full_cnt(s.reload_value);
    s.reload_pending = 1'b0;
    s.awaiting_count = 1'b0;
    case (s.counter_mode)
      3'd0: begin
        s.current_count = n; s.out_level = 1'b0; s.terminal_hit = 1'b0;
        s.count_enabled = s.gate_store;
      end
      3'd2: begin
        if (s.first_load) begin
          s.current_count = n - 17'd1; s.out_level = 1'b1; s.terminal_hit = 1'b0;
        end
        s.count_enabled = s.gate_store;
      end
      3'd3: begin
        if (s.first_load) begin
          s.current_count = n; s.out_level = 1'b1; s.terminal_hit = 1'b0;
        end
        s.count_enabled = s.gate_store;
      end
      3'd4: begin
        if (!s.terminal_hit && !s.first_load) s.reload_pending = 1'b1;
        else begin
          s.current_count = n; s.out_level = 1'b0; s.terminal_hit = 1'b0;
        end
        s.count_enabled = s.gate_store;
      end
      default: s.count_enabled = 1'b1;
    endcase
    s.first_load = 1'b0;
    return s;
  endfunction

  // terminal count handling
  function automatic cnt_state_t expire(input cnt_state_t si);
    cnt_state_t s;
    logic [16:0] n;
    s = si;
    n = full_cnt(s.reload_value);
    if (s.awaiting_count) begin
      s.current_count = s.current_count + 17'h0ffff;
    end else begin
      case (s.counter_mode)
        3'd2: begin
          s.current_count = s.current_count + n; s.out_level = 1'b1;
        end
        3'd3: begin
          s.out_level = !s.out_level;
          s.current_count = s.current_count + n;
        end
        3'd4: begin
          if (!s.terminal_hit) s.out_level = 1'b1;
          if (s.reload_pending) begin
            s.reload_pending = 1'b0;
            s.current_count = s.current_count + n;
          end else begin
            s.terminal_hit = 1'b1;
            s.current_count = s.current_count + 17'h0ffff;
          end
        end
        default: begin
          if (!s.terminal_hit) s.out_level = 1'b1;
          s.terminal_hit = 1'b1;
          s.current_count = s.current_count + 17'h0ffff;
        end
      endcase
    end
    return s;
  endfunction

  // next state for the one request of this cycle
  always_comb begin
    cnt_state_t s;
    logic [16:0] n, cnt, d;
    logic        rise;
    logic [2:0]  m;
    s = st;
    n = full_cnt(st.reload_value);
    cnt = st.current_count;
    d = 17'd1;
    rise = 1'b0;
    m = 3'd0;
    rd_byte = 8'd0;
    if (en && req.ctl_write) begin
      if (req.data[5:4] == 2'b00) begin
        s.output_latch = live_cnt(st);
        s.reread_pending = 1'b0;
        s.read_access_state = 2'd3;
        s.latch_held = 1'b1;
      end else begin
        m = req.data[3:1];
        if (m > 3'd5) m = {1'b0, m[1:0]};
        s.control_copy = req.data;
        s.read_access_state = req.data[5:4];
        s.write_access_state = req.data[5:4];
        s.counter_mode = m;
        s.reread_pending = 1'b1;
        s.first_load = 1'b1;
        s.out_level = (m != 3'd0);
        s.awaiting_count = 1'b1;
      end
      s.terminal_hit = 1'b0;
    end
    if (en && (req.rb_count || req.rb_status)) begin
      if (req.rb_count) s.output_latch = live_cnt(st);
      if (req.rb_status) begin
        s.status_byte = {st.out_level, 1'b0, st.control_copy[5:0]};
        s.status_pending = 1'b1;
      end
    end
    if (en && req.wr_data) begin
      case (st.write_access_state)
        2'd1: begin s.reload_value = {8'd0, req.data}; s = do_load(s); end
        2'd2: begin s.reload_value = {req.data, 8'd0}; s = do_load(s); end
        2'd0: begin
          s.reload_value = {req.data, st.reload_value[7:0]};
          s = do_load(s);
          s.write_access_state = 2'd3;
        end
        default: begin
          s.reload_value = {st.reload_value[15:8], req.data};
          s.write_access_state = 2'd0;
        end
      endcase
    end
    if (en && req.rd_data) begin
      if (st.status_pending) begin
        s.status_pending = 1'b0;
        rd_byte = st.status_byte;
      end else begin
        if (st.reread_pending && !st.latch_held) begin
          s.reread_pending = 1'b0;
          s.output_latch = live_cnt(st);
        end
        case (st.read_access_state)
          2'd0: begin
            rd_byte = s.output_latch[15:8];
            s.read_access_state = 2'd3; s.latch_held = 1'b0; s.reread_pending = 1'b1;
          end
          2'd1: begin
            rd_byte = s.output_latch[7:0];
            s.latch_held = 1'b0; s.reread_pending = 1'b1;
          end
          2'd2: begin
            rd_byte = s.output_latch[15:8];
            s.latch_held = 1'b0; s.reread_pending = 1'b1;
          end
          default: begin
            rd_byte = s.output_latch[7:0];
            s.read_access_state = 2'd0;
          end
        endcase
      end
    end
    if (en && req.gate_chg) begin
      rise = req.gate_level && !st.gate_store;
      if (!st.awaiting_count) begin
        case (st.counter_mode)
          3'd1, 3'd5: begin
            if (rise) begin
              s.current_count = n; s.out_level = 1'b0; s.terminal_hit = 1'b0;
              s.count_enabled = 1'b1;
            end
          end
          3'd2: begin
            if (rise) begin
              s.current_count = n - 17'd1; s.out_level = 1'b1; s.terminal_hit = 1'b0;
            end
            s.count_enabled = req.gate_level;
          end
          3'd3: begin
            if (rise) begin
              s.current_count = n; s.out_level = 1'b1; s.terminal_hit = 1'b0;
            end
            s.count_enabled = req.gate_level;
          end
          default: s.count_enabled = req.gate_level;
        endcase
      end
      s.gate_store = req.gate_level;
    end
    if (en && req.tick && !st.terminal_hit && st.count_enabled) begin
      if (st.counter_mode == 3'd3) begin
        d = cnt[0] ? (st.out_level ? 17'd1 : 17'd3) : 17'd2;
        if (cnt != 17'd0 && cnt <= d) cnt = 17'd0;
        else cnt = cnt - d;
      end else begin
        cnt = cnt - 17'd1;
      end
      s.current_count = cnt;
      if (cnt == 17'd0) s = expire(s);
    end
    st_next = s;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      st.reload_value <= 16'hffff;
      st.gate_store <= gate_init;
      st.terminal_hit <= term_init;
    end else begin
      st <= st_next;
    end
  end

  assign out_level = st.out_level;

  // a pending status read returns the stored status byte
  assert property (@(posedge clk) disable iff (rst)
    (en && req.rd_data && st.status_pending) |-> (rd_byte == st.status_byte))
    else $error("status byte not returned");
  // a control write leaves the counter awaiting a count or latched
  assert property (@(posedge clk) disable iff (rst)
    (en && req.ctl_write && req.data[5:4] != 2'b00) |=> st.awaiting_count)
    else $error("control write did not arm counter");
  // ticks never move a stopped counter
  assert property (@(posedge clk) disable iff (rst)
    (en && req.tick && st.terminal_hit && !req.gate_chg) |=>
      $stable(st.current_count))
    else $error("count moved after terminal count");

endmodule

>>> rtl/interval_timer_three_counter.sv
// Three-counter interval timer (8254 style), one operation per input transfer.
// Input stream s_axis: tdata carries action, bus_addr, write_data, counter_sel,
// gate_level. Each action is a bus write, a bus read, a gate change or one
// clock tick of one counter.
// Output stream m_axis: one transfer per input, carrying the byte read (zero
// unless a read) and the three counter output levels after the operation.
// The result goes to an output register and is valid in the cycle after the
// input transfer. Throughput: one item per cycle while the receiver does not
// stall; state updates in the cycle of acceptance.
// The input is taken whenever the output register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and backpressures
// the input after one item.
// Reset (rst, synchronous) puts all counters to their power-up state:
// reload 0xffff, mode 0, gates 1,1,0, counter 0 terminal, no result pending.
module interval_timer_three_counter
  import itc_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action, [3:2] bus_addr, [11:4] write_data, [13:12] counter_sel,
  // [14] gate_level
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [10:8] out_levels
  output logic [15:0] m_axis_tdata
);

  logic       accept;
  logic [1:0] act;
  logic [1:0] addr;
  logic [7:0] wdata;
  logic [1:0] sel;
  logic       glevel;
  logic [7:0] last_control, last_control_next;
  logic [7:0] rd_next;
  logic [7:0] rd_bytes [3];
  logic [2:0] levels;
  logic       out_valid;
  logic [10:0] out_data;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign act = s_axis_tdata[1:0];
  assign addr = s_axis_tdata[3:2];
  assign wdata = s_axis_tdata[11:4];
  assign sel = s_axis_tdata[13:12];
  assign glevel = s_axis_tdata[14];

  // counters
  for (genvar c = 0; c < 3; c++) begin : g_cnt
    if (c < NUM_COUNTERS) begin : g_on
      cnt_req_t req;
      logic     lvl;
      always_comb begin
        req = '0;
        req.data = wdata;
        req.gate_level = glevel;
        req.wr_data = (act == ACT_WRITE) && (addr == 2'(c));
        req.rd_data = (act == ACT_READ) && (addr == 2'(c));
        req.gate_chg = (act == ACT_GATE) && (sel == 2'(c));
        req.tick = (act == ACT_TICK) && (sel == 2'(c));
        req.ctl_write = (act == ACT_WRITE) && (addr == AddrControl) &&
                        (wdata[7:6] == 2'(c));
        req.rb_count = (act == ACT_WRITE) && (addr == AddrControl) &&
                       (wdata[7:6] == 2'b11) && wdata[c+1] && !wdata[5];
        req.rb_status = (act == ACT_WRITE) && (addr == AddrControl) &&
                        (wdata[7:6] == 2'b11) && wdata[c+1] && !wdata[4];
      end
      itc_counter u_cnt (
        .clk       (clk),
        .rst       (rst),
        .en        (accept),
        .gate_init (c < 2),
        .term_init (c == 0),
        .req       (req),
        .rd_byte   (rd_bytes[c]),
        .out_level (lvl)
      );
      assign levels[c] = lvl;
    end else begin : g_off
      assign rd_bytes[c] = 8'hff;
      assign levels[c] = 1'b0;
    end
  end

  // control register and read mux
  always_comb begin
    last_control_next = last_control;
    if (act == ACT_WRITE && addr == AddrControl && wdata[7:6] != 2'b11) begin
      last_control_next = (wdata[5:4] == 2'b00 && 32'(wdata[7:6]) < NUM_COUNTERS) ?
                          (wdata | 8'h30) : wdata;
    end
    rd_next = 8'd0;
    if (act == ACT_READ) begin
      if (addr == AddrControl) rd_next = last_control;
      else rd_next = rd_bytes[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_control <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        last_control <= last_control_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register; levels are read after the counters update
  logic [7:0] rd_hold;
  logic       lvl_take;
  always_ff @(posedge clk) begin
    if (accept) rd_hold <= rd_next;
  end
  always_ff @(posedge clk) begin
    if (rst) lvl_take <= 1'b0;
    else lvl_take <= accept;
  end
  logic [2:0] lvl_hold;
  always_ff @(posedge clk) begin
    if (lvl_take) lvl_hold <= levels;
  end
  assign out_data = {lvl_take ? levels : lvl_hold, rd_hold};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_data};

  // a result is never dropped while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped under stall");
  // no input taken while a stalled result is held
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken over held result");
  // every accepted item yields a valid result next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("missing result");

endmodule
